// ----- design/ctsw_pkg.sv -----
// Shared types, constants and CRC helpers for the config TLV stream walker.
package ctsw_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 96;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int SIZE_W      = 16;
    localparam int NUM_IDS     = 15;
    localparam int SLOT_W      = 4;
    localparam int SLOTS_PER_REG = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_WORD_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_WORD_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_WORD_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_WORD_3 = 2'd3;

    // Result kinds
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Walk status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_SHORT = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // One classified blob byte, front to back
    typedef struct packed {
        logic [7:0]  byte_val;    // pre-trailer byte released by the delay line
        logic        has_byte;
        logic        p_zero;
        logic        p_one;
        logic        p_two;
        logic [15:0] body_off;    // offset of the byte after this one
        logic        last;
        logic        short_blob;
        logic [15:0] trailer;
    } entry_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  record_id;
        logic [15:0] body_offset;
        logic [15:0] record_size;
        logic [1:0]  walk_status;
        logic [7:0]  unknown_id;
        logic [7:0]  version;
        logic [15:0] crc_computed;
        logic [15:0] crc_trailer;
        logic        last_result;
    } result_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // CRC state after byte 1: restart and feed two zero bytes
    localparam logic [15:0] CRC_TWO_ZEROS = crc16_feed(crc16_feed(CRC_INIT, 8'h00), 8'h00);

    // Known id to table slot; MSB is the hit flag
    function automatic logic [SLOT_W:0] id_slot(input logic [7:0] id);
        logic [SLOT_W:0] r;
        case (id)
            8'h01: r = {1'b1, 4'd0};
            8'h02: r = {1'b1, 4'd1};
            8'h04: r = {1'b1, 4'd2};
            8'h20: r = {1'b1, 4'd3};
            8'h21: r = {1'b1, 4'd4};
            8'h23: r = {1'b1, 4'd5};
            8'h24: r = {1'b1, 4'd6};
            8'h25: r = {1'b1, 4'd7};
            8'h26: r = {1'b1, 4'd8};
            8'h27: r = {1'b1, 4'd9};
            8'h28: r = {1'b1, 4'd10};
            8'h29: r = {1'b1, 4'd11};
            8'h2A: r = {1'b1, 4'd12};
            8'h2B: r = {1'b1, 4'd13};
            8'h2C: r = {1'b1, 4'd14};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/ctsw_front.sv -----
// Front end: byte intake, two-byte trailer delay line, byte counter, classification.
module ctsw_front #(
    parameter int MAX_BLOB_BYTES = 65536
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ctsw_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    output logic                          push_valid,
    input  logic                          push_ready,
    output ctsw_pkg::entry_t              push_entry
);
    import ctsw_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOB_BYTES + 1);
    localparam int EXT_W = (CNT_W > 16) ? CNT_W : 16;

    logic [7:0]       tail0_reg, tail0_next;
    logic [7:0]       tail1_reg, tail1_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [EXT_W-1:0] count_ext;
    logic             accept;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign accept     = s_tvalid && push_ready;
    assign count_ext  = EXT_W'(count_reg);

    always_comb begin
        push_entry.byte_val   = tail1_reg;
        push_entry.has_byte   = (count_reg >= CNT_W'(2));
        push_entry.p_zero     = (count_reg == CNT_W'(2));
        push_entry.p_one      = (count_reg == CNT_W'(3));
        push_entry.p_two      = (count_reg == CNT_W'(4));
        push_entry.body_off   = 16'(count_ext - EXT_W'(1));
        push_entry.last       = s_tlast;
        push_entry.short_blob = (count_reg < CNT_W'(4));
        push_entry.trailer    = {tail0_reg, s_tdata};
    end

    always_comb begin
        tail0_next = tail0_reg;
        tail1_next = tail1_reg;
        count_next = count_reg;
        if (accept) begin
            if (s_tlast) begin
                tail0_next = '0;
                tail1_next = '0;
                count_next = '0;
            end else begin
                tail1_next = tail0_reg;
                tail0_next = s_tdata;
                if (count_reg != CNT_W'(MAX_BLOB_BYTES)) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail0_reg <= '0;
            tail1_reg <= '0;
            count_reg <= '0;
        end else begin
            tail0_reg <= tail0_next;
            tail1_reg <= tail1_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/ctsw_fifo.sv -----
// Short register queue decoupling the front end from the walker.
module ctsw_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  ctsw_pkg::entry_t push_entry,
    output logic             pop_valid,
    input  logic             pop_ready,
    output ctsw_pkg::entry_t pop_entry
);
    import ctsw_pkg::*;

    entry_t             slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   fill_reg, fill_next;
    logic               do_push, do_pop;

    assign push_ready = (fill_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + (FIFO_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- design/ctsw_back.sv -----
// Walker: size table, CRC, packet phase tracking and result output stage.
module ctsw_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [ctsw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ctsw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  ctsw_pkg::entry_t                 pop_entry,
    output logic                             out_valid,
    input  logic                             out_ready,
    output ctsw_pkg::result_t                out_result
);
    import ctsw_pkg::*;

    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_RESERVED = 3'd1;
    localparam logic [2:0] PH_ID       = 3'd2;
    localparam logic [2:0] PH_BODY     = 3'd3;
    localparam logic [2:0] PH_STOPPED  = 3'd4;

    logic [SIZE_W-1:0] size_tab_reg [NUM_IDS];

    logic [15:0] crc_reg, crc_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  cur_id_reg, cur_id_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] start_reg, start_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  stopped_reg, stopped_next;

    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        hold_valid_reg, hold_valid_next;
    result_t     hold_reg, hold_next;

    logic [SLOT_W:0]   slot_hit;
    logic [15:0]       lookup_sz;
    logic [SLOT_W:0]   cur_slot;
    logic [15:0]       cur_sz;
    logic              can_load;
    logic              pkt_done;
    result_t           desc, stat;

    // Size table writes: each register fills four slots, the last one three
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_IDS; i++) begin
                size_tab_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            for (int k = 0; k < SLOTS_PER_REG; k++) begin
                if ((int'(cfg_index) * SLOTS_PER_REG + k) < NUM_IDS) begin
                    size_tab_reg[SLOT_W'(int'(cfg_index) * SLOTS_PER_REG + k)] <=
                        cfg_data[k*SIZE_W +: SIZE_W];
                end
            end
        end
    end

    assign slot_hit  = id_slot(pop_entry.byte_val);
    assign lookup_sz = slot_hit[SLOT_W] ? size_tab_reg[slot_hit[SLOT_W-1:0]] : 16'd0;

    // descriptor size is read from the table as it stands when the body ends
    assign cur_slot  = id_slot(cur_id_reg);
    assign cur_sz    = cur_slot[SLOT_W] ? size_tab_reg[cur_slot[SLOT_W-1:0]] : 16'd0;

    // Walker state update for the head entry
    always_comb begin
        crc_next     = crc_reg;
        phase_next   = phase_reg;
        cur_id_next  = cur_id_reg;
        remain_next  = remain_reg;
        start_next   = start_reg;
        version_next = version_reg;
        stopped_next = stopped_reg;
        pkt_done     = 1'b0;
        if (pop_entry.has_byte) begin
            if (pop_entry.p_zero) begin
                crc_next = crc16_feed(CRC_INIT, pop_entry.byte_val);
            end else if (pop_entry.p_one) begin
                crc_next = CRC_TWO_ZEROS;
            end else begin
                crc_next = crc16_feed(crc_reg, pop_entry.byte_val);
            end
            case (phase_reg)
                PH_HEADER: begin
                    if (pop_entry.p_two) begin
                        version_next = pop_entry.byte_val;
                        phase_next   = PH_RESERVED;
                    end
                end
                PH_RESERVED: begin
                    phase_next = PH_ID;
                end
                PH_ID: begin
                    if (lookup_sz == 16'd0) begin
                        stopped_next = pop_entry.byte_val;
                        phase_next   = PH_STOPPED;
                    end else begin
                        cur_id_next = pop_entry.byte_val;
                        remain_next = lookup_sz;
                        start_next  = pop_entry.body_off;
                        phase_next  = PH_BODY;
                    end
                end
                PH_BODY: begin
                    remain_next = remain_reg - 16'd1;
                    if (remain_reg == 16'd1) begin
                        phase_next = PH_RESERVED;
                        pkt_done   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        desc              = '0;
        desc.kind         = KIND_PACKET;
        desc.record_id    = cur_id_reg;
        desc.body_offset  = start_reg;
        desc.record_size  = cur_sz;
        desc.last_result  = !pop_entry.last;

        stat              = '0;
        stat.kind         = KIND_STATUS;
        stat.crc_computed = crc_next;
        stat.crc_trailer  = pop_entry.trailer;
        stat.last_result  = 1'b1;
        if (pop_entry.short_blob) begin
            stat.walk_status = ST_TOO_SHORT;
        end else if (phase_next == PH_BODY) begin
            stat.walk_status = ST_TRUNCATED;
            stat.version     = version_next;
        end else begin
            stat.walk_status = ST_OK;
            stat.version     = version_next;
            stat.unknown_id  = stopped_next;
        end
    end

    assign can_load   = !out_valid_reg || out_ready;
    assign pop_ready  = can_load && !hold_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // Output register plus one hold slot for the second result of an entry
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (can_load) begin
            out_valid_next = 1'b0;
            if (hold_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = hold_reg;
                hold_valid_next = 1'b0;
            end else if (pop_valid) begin
                if (pkt_done) begin
                    out_valid_next = 1'b1;
                    out_next       = desc;
                    if (pop_entry.last) begin
                        hold_valid_next = 1'b1;
                        hold_next       = stat;
                    end
                end else if (pop_entry.last) begin
                    out_valid_next = 1'b1;
                    out_next       = stat;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            crc_reg        <= CRC_INIT;
            phase_reg      <= PH_HEADER;
            cur_id_reg     <= '0;
            remain_reg     <= '0;
            start_reg      <= '0;
            version_reg    <= '0;
            stopped_reg    <= '0;
        end else begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
            if (pop_valid && pop_ready) begin
                if (pop_entry.last) begin
                    crc_reg     <= CRC_INIT;
                    phase_reg   <= PH_HEADER;
                    cur_id_reg  <= '0;
                    remain_reg  <= '0;
                    start_reg   <= '0;
                    version_reg <= '0;
                    stopped_reg <= '0;
                end else begin
                    crc_reg     <= crc_next;
                    phase_reg   <= phase_next;
                    cur_id_reg  <= cur_id_next;
                    remain_reg  <= remain_next;
                    start_reg   <= start_next;
                    version_reg <= version_next;
                    stopped_reg <= stopped_next;
                end
            end
        end
    end

endmodule

// ----- design/config_tlv_stream_walker.sv -----
// Top level of the config TLV stream walker: front end, queue, walker.
//
//  channel   direction  handshake             payload
//  s_        in         s_tvalid / s_tready   tdata: data_byte; tlast: last_byte
//  m_        out        m_tvalid / m_tready   tdata: packet fields; tuser: kind;
//                                             tlast: last result of its word
//  cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data (size table)
//
//  One input word per cycle while m_ is not stalled and no hold-slot result
//  waits; CRC step, id lookup and packet bookkeeping are all combinational.
//  A final byte that also completes a packet yields two result words, the
//  second leaving through the hold slot once the first is taken.
//  Input to result path: the queue, then the output register.
//  aresetn is synchronous, active low; it clears the size table and walk state.
//  A stalled m_ side backs up into the four-entry queue before s_tready drops.
module config_tlv_stream_walker #(
    parameter int MAX_BLOB_BYTES = 65536
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // slave stream: tdata = data_byte[7:0]; tlast = last_byte
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ctsw_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tlast,
    // master stream: tdata = record_id[7:0], body_offset[23:8], record_size[39:24],
    //   walk_status[41:40], unknown_id[49:42], version[57:50],
    //   crc_computed[73:58], crc_trailer[89:74], zero pad[95:90]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ctsw_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // tuser = result_kind
    output logic                              m_tuser,
    output logic                              m_tlast,
    // configuration write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ctsw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ctsw_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ctsw_pkg::*;

    logic    push_valid, push_ready;
    entry_t  push_entry;
    logic    pop_valid, pop_ready;
    entry_t  pop_entry;
    result_t res;

    // Table writes never stall
    assign cfg_ready = 1'b1;

    ctsw_front #(
        .MAX_BLOB_BYTES (MAX_BLOB_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    ctsw_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    ctsw_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    // Pack result fields, first field lowest
    assign m_tdata = {6'b0, res.crc_trailer, res.crc_computed, res.version,
                      res.unknown_id, res.walk_status, res.record_size,
                      res.body_offset, res.record_id};
    assign m_tuser = res.kind;
    assign m_tlast = res.last_result;

endmodule

// ----- design/ctsw_checker.sv -----
// Port-level checker for the config TLV stream walker, bound to the top level.
module ctsw_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ctsw_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                              m_tuser,
    input logic                              m_tlast
);
    import ctsw_pkg::*;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Nothing pending right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A status word always closes its input word's results
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_STATUS) |-> m_tlast)
        else $error("status word without tlast");

    // Packet descriptors carry a nonzero size and no status fields
    a_desc_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_PACKET) |-> (m_tdata[39:24] != 16'd0)
                                             && (m_tdata[89:40] == '0))
        else $error("bad packet descriptor");

    // Status code is never the unused encoding
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_STATUS) |-> (m_tdata[41:40] != 2'd3))
        else $error("bad walk status code");

endmodule

bind config_tlv_stream_walker ctsw_checker u_ctsw_checker (.*);

// ----- test/tb_config_tlv_stream_walker.sv -----
// Self-checking testbench for config_tlv_stream_walker: blob walk, size table, CRC.
module tb_config_tlv_stream_walker;
    import ctsw_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int MAX_BLOB_BYTES = 65536;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int PHASES         = 6;
    // idle time after a drain before touching the table
    localparam int DRAIN_CYCLES   = 8;
    // one receiver hold-off long enough to back up the four-entry queue
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AFTER     = 20;
    // no accepted word for this long means the block is hung
    localparam int STALL_LIMIT    = 5000;

    // the 15 known ids, slot 0 in the low byte
    localparam logic [NUM_IDS*8-1:0] KNOWN_IDS = {
        8'h2C, 8'h2B, 8'h2A, 8'h29, 8'h28, 8'h27, 8'h26, 8'h25,
        8'h24, 8'h23, 8'h21, 8'h20, 8'h04, 8'h02, 8'h01
    };

    typedef enum logic [2:0] {
        WALK_HEADER, WALK_RESERVED, WALK_ID, WALK_BODY, WALK_STOPPED
    } walk_phase_e;

    // how a size table is filled for one phase of the run
    typedef enum int {
        TAB_ZERO, TAB_ONES, TAB_TINY, TAB_SMALL, TAB_MIXED
    } table_style_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } blob_word_t;

    // ------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #2 aclk = ~aclk;
    end

    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic                    s_tlast = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tuser;
    logic                    m_tlast;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    config_tlv_stream_walker #(
        .MAX_BLOB_BYTES(MAX_BLOB_BYTES)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // walker model: own copy of the size table and the walk state
    // ------------------------------------------------------------------
    logic [63:0]  size_tab [4];
    logic [7:0]   dly_new, dly_old;     // two-byte delay that hides the trailer
    int unsigned  blob_len;             // saturating byte count
    logic [15:0]  crc_acc;
    walk_phase_e  phase;
    logic [7:0]   pkt_id, ver_byte, stop_id;
    logic [15:0]  body_left, body_at;

    result_t      blob_results_due [$];
    blob_word_t   blob_bytes_q [$];

    int items_sent, bytes_in, blobs_made, cfg_writes;
    int results_seen, descriptors_seen, reports_seen, mismatches;

    // CRC-16/CCITT-FALSE, one data bit at a time, MSB first
    function automatic logic [15:0] ccitt_step(logic [15:0] c, logic [7:0] d);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // body size of an id, 0 when the id is not in the table
    function automatic logic [15:0] table_size(logic [7:0] id);
        for (int i = 0; i < NUM_IDS; i++) begin
            if (KNOWN_IDS[i*8 +: 8] == id) begin
                return size_tab[i/4][(i%4)*16 +: 16];
            end
        end
        return 16'h0000;
    endfunction

    function automatic void restart_walk();
        dly_new   = '0;
        dly_old   = '0;
        blob_len  = 0;
        crc_acc   = CRC_INIT;
        phase     = WALK_HEADER;
        pkt_id    = '0;
        body_left = '0;
        body_at   = '0;
        ver_byte  = '0;
        stop_id   = '0;
    endfunction

    // one accepted blob byte; queues the descriptor and/or report it causes
    function automatic void walk_blob_byte(logic [7:0] b, logic last);
        result_t     r;
        int unsigned n;
        int unsigned p;
        logic [15:0] sz;
        n = blob_len;
        // the byte two back is now known to sit before the trailer
        if (n >= 2) begin
            p = n - 2;
            if (p == 0) begin
                crc_acc = ccitt_step(CRC_INIT, dly_old);
            end else if (p == 1) begin
                // the length field restarts the CRC as two zero bytes
                crc_acc = ccitt_step(ccitt_step(CRC_INIT, 8'h00), 8'h00);
            end else begin
                crc_acc = ccitt_step(crc_acc, dly_old);
            end
            case (phase)
                WALK_HEADER: begin
                    if (p == 2) begin
                        ver_byte = dly_old;
                        phase    = WALK_RESERVED;
                    end
                end
                WALK_RESERVED: begin
                    phase = WALK_ID;
                end
                WALK_ID: begin
                    sz = table_size(dly_old);
                    if (sz == 16'h0000) begin
                        stop_id = dly_old;
                        phase   = WALK_STOPPED;
                    end else begin
                        pkt_id    = dly_old;
                        body_left = sz;
                        body_at   = 16'(p + 1);
                        phase     = WALK_BODY;
                    end
                end
                WALK_BODY: begin
                    body_left = body_left - 16'd1;
                    if (body_left == 16'h0000) begin
                        phase         = WALK_RESERVED;
                        r             = '0;
                        r.kind        = KIND_PACKET;
                        r.record_id   = pkt_id;
                        r.body_offset = body_at;
                        r.record_size = table_size(pkt_id);
                        r.last_result = !last;
                        blob_results_due.push_back(r);
                    end
                end
                default: begin
                end
            endcase
        end
        dly_old = dly_new;
        dly_new = b;
        if (blob_len < MAX_BLOB_BYTES) begin
            blob_len++;
        end
        if (last) begin
            r              = '0;
            r.kind         = KIND_STATUS;
            r.crc_computed = crc_acc;
            r.crc_trailer  = {dly_old, dly_new};
            r.last_result  = 1'b1;
            if (n + 1 < 5) begin
                r.walk_status = ST_TOO_SHORT;
            end else if (phase == WALK_BODY) begin
                r.walk_status = ST_TRUNCATED;
                r.version     = ver_byte;
            end else begin
                r.walk_status = ST_OK;
                r.version     = ver_byte;
                r.unknown_id  = stop_id;
            end
            blob_results_due.push_back(r);
            restart_walk();
        end
    endfunction

    initial begin
        for (int i = 0; i < 4; i++) begin
            size_tab[i] = '0;
        end
        restart_walk();
    end

    // ------------------------------------------------------------------
    // idle patterns: mostly short gaps, a few long ones
    // ------------------------------------------------------------------
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // input driver: offers queued blob bytes, predicts on acceptance
    // ------------------------------------------------------------------
    logic in_taken = 1'b0;
    int   src_gap = 0;
    bit   src_steady = 1'b0;        // stretches with no sender gaps

    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready;
    end

    always @(negedge aclk) begin
        if (in_taken) begin
            walk_blob_byte(blob_bytes_q[0].data, blob_bytes_q[0].last);
            void'(blob_bytes_q.pop_front());
            bytes_in++;
        end
        if ($urandom_range(0, 199) == 0) begin
            src_steady = !src_steady;
        end
        // an offered word stays put until it is taken
        if (!s_tvalid || in_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (blob_bytes_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= blob_bytes_q[0].data;
                s_tlast  <= blob_bytes_q[0].last;
                src_gap  = src_steady ? 0 : draw_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------
    int  sink_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  sink_steady = 1'b0;

    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0) begin
            sink_steady = !sink_steady;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            // sender keeps going, so the queue fills and s_tready drops
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!sink_steady && $urandom_range(0, 3) == 0) begin
                sink_gap = draw_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: each result word against the oldest prediction
    // ------------------------------------------------------------------
    function automatic void note_miss(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", what, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (m_tvalid && m_tready) begin
            got              = '0;
            got.kind         = m_tuser;
            got.record_id    = m_tdata[7:0];
            got.body_offset  = m_tdata[23:8];
            got.record_size  = m_tdata[39:24];
            got.walk_status  = m_tdata[41:40];
            got.unknown_id   = m_tdata[49:42];
            got.version      = m_tdata[57:50];
            got.crc_computed = m_tdata[73:58];
            got.crc_trailer  = m_tdata[89:74];
            got.last_result  = m_tlast;
            results_seen++;
            if (got.kind == KIND_PACKET) begin
                descriptors_seen++;
            end else begin
                reports_seen++;
            end
            if (blob_results_due.size() == 0) begin
                mismatches++;
                $error("result word with nothing predicted: kind %0b tdata 0x%0h",
                       m_tuser, m_tdata);
            end else begin
                want = blob_results_due.pop_front();
                note_miss("result_kind", 16'(want.kind), 16'(got.kind));
                note_miss("record_id", 16'(want.record_id), 16'(got.record_id));
                note_miss("body_offset", want.body_offset, got.body_offset);
                note_miss("record_size", want.record_size, got.record_size);
                note_miss("walk_status", 16'(want.walk_status), 16'(got.walk_status));
                note_miss("unknown_id", 16'(want.unknown_id), 16'(got.unknown_id));
                note_miss("version", 16'(want.version), 16'(got.version));
                note_miss("crc_computed", want.crc_computed, got.crc_computed);
                note_miss("crc_trailer", want.crc_trailer, got.crc_trailer);
                note_miss("last_result", 16'(want.last_result), 16'(got.last_result));
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: counts cycles with no word moving on any channel
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $error("no word accepted for %0d cycles, %0d results still due",
                       STALL_LIMIT, blob_results_due.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send(logic [7:0] b, logic last);
        blob_word_t w;
        w.data = b;
        w.last = last;
        blob_bytes_q.push_back(w);
        items_sent++;
    endtask

    // wait until every queued byte is taken and every result has come back
    task automatic drain();
        while (blob_bytes_q.size() != 0 || blob_results_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // table writes only while the walker is idle
    task automatic write_size_word(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        // size_word_3 only keeps its three slots
        size_tab[idx] = (idx == REG_SIZE_WORD_3) ? (val & 64'h0000_FFFF_FFFF_FFFF) : val;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] draw_slot(table_style_e s);
        int r;
        r = $urandom_range(0, 99);
        case (s)
            TAB_ZERO:  return 16'h0000;
            TAB_ONES:  return 16'hFFFF;
            TAB_TINY:  return 16'($urandom_range(1, 6));
            TAB_SMALL: return 16'($urandom_range(0, 6));
            default: begin
                if (r < 15) begin
                    return 16'h0000;
                end
                if (r < 65) begin
                    return 16'($urandom_range(1, 8));
                end
                if (r < 90) begin
                    return 16'($urandom_range(9, 40));
                end
                return 16'($urandom_range(16'hFFF0, 16'hFFFF));
            end
        endcase
    endfunction

    function automatic logic [63:0] draw_word(table_style_e s);
        return {draw_slot(s), draw_slot(s), draw_slot(s), draw_slot(s)};
    endfunction

    task automatic load_table(table_style_e s);
        logic [63:0] top_word;
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_size_word(REG_SIZE_WORD_0, draw_word(s));
        write_size_word(REG_SIZE_WORD_1, draw_word(s));
        write_size_word(REG_SIZE_WORD_2, draw_word(s));
        // junk in the unused top slot must be dropped
        top_word = draw_word(s);
        write_size_word(REG_SIZE_WORD_3, {16'($urandom), top_word[47:0]});
        @(posedge aclk);
    endtask

    function automatic logic [7:0] draw_known_id();
        int slot;
        slot = $urandom_range(0, NUM_IDS - 1);
        return KNOWN_IDS[slot*8 +: 8];
    endfunction

    // one blob: mostly well formed with random content, some short or noise
    task automatic make_blob();
        int          pick;
        int          npk;
        int          lim;
        logic [7:0]  id;
        logic [15:0] sz;
        blobs_made++;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            npk = $urandom_range(1, 4);
            for (int k = 0; k < npk; k++) begin
                send(8'($urandom), k == npk - 1);
            end
            return;
        end
        if (pick < 15) begin
            npk = $urandom_range(5, 30);
            for (int k = 0; k < npk; k++) begin
                send(8'($urandom), k == npk - 1);
            end
            return;
        end
        repeat (3) send(8'($urandom), 1'b0);      // length field, version
        npk = $urandom_range(0, 6);
        for (int k = 0; k < npk; k++) begin
            send(8'($urandom), 1'b0);             // reserved byte
            if ($urandom_range(0, 19) == 0) begin
                break;                            // trailer between reserved and id
            end
            id = ($urandom_range(0, 4) == 0) ? 8'($urandom) : draw_known_id();
            send(id, 1'b0);
            sz = table_size(id);
            if (sz == 16'h0000) begin
                // unknown id: the rest only feeds the CRC
                repeat ($urandom_range(0, 4)) send(8'($urandom), 1'b0);
                break;
            end
            if (sz > 16'd40 || $urandom_range(0, 9) == 0) begin
                // body cut short by the trailer
                lim = (sz > 16'd12) ? 12 : int'(sz) - 1;
                repeat ($urandom_range(0, lim)) send(8'($urandom), 1'b0);
                break;
            end
            repeat (sz) send(8'($urandom), 1'b0);
        end
        send(8'($urandom), 1'b0);
        send(8'($urandom), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        table_style_e plan [PHASES];
        int           start;
        plan = '{TAB_SMALL, TAB_MIXED, TAB_ONES, TAB_ZERO, TAB_MIXED, TAB_TINY};

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset table (every id unknown)
        send(8'hFF, 1'b1);                        // one byte: trailer high byte reads 0
        send(8'h00, 1'b0);                        // three bytes: CRC over byte 0
        send(8'hFF, 1'b0);
        send(8'hA5, 1'b1);
        send(8'h00, 1'b0);                        // four bytes: still too short
        send(8'hFF, 1'b0);
        send(8'h00, 1'b0);
        send(8'hFF, 1'b1);
        send(8'h00, 1'b0);                        // id 0x01 unknown: walk stops OK
        send(8'h07, 1'b0);
        send(8'hFF, 1'b0);
        send(8'h00, 1'b0);
        send(8'h01, 1'b0);
        send(8'h12, 1'b0);
        send(8'h34, 1'b1);
        blobs_made += 4;
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        // 0x01 one byte, 0x02 two, 0x04 unknown, 0x20 the largest body
        write_size_word(REG_SIZE_WORD_0, {16'hFFFF, 16'h0000, 16'h0002, 16'h0001});
        write_size_word(REG_SIZE_WORD_1, {4{16'h0003}});
        write_size_word(REG_SIZE_WORD_2, {4{16'h0001}});
        write_size_word(REG_SIZE_WORD_3, 64'hFFFF_0004_0002_0001);
        @(posedge aclk);

        send(8'h00, 1'b0);
        send(8'h09, 1'b0);
        send(8'h5A, 1'b0);
        send(8'hFF, 1'b0);
        send(8'h01, 1'b0);
        send(8'hAA, 1'b0);
        // sender pauses mid-blob until the bytes so far are taken
        drain();
        send(8'h00, 1'b0);
        send(8'h20, 1'b0);                        // body of 0xFFFF gets truncated
        send(8'h33, 1'b0);
        send(8'hBE, 1'b0);
        send(8'hEF, 1'b1);
        blobs_made++;

        // random phases, each under its own size table
        for (int ph = 0; ph < PHASES; ph++) begin
            load_table(plan[ph]);
            start = items_sent;
            while (items_sent - start < RANDOM_ITEMS / PHASES) begin
                make_blob();
            end
        end
        repeat (3) make_blob();

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("walked %0d bytes in %0d blobs, %0d size table writes",
                 bytes_in, blobs_made, cfg_writes);
        $display("checked %0d result words: %0d packet descriptors, %0d blob reports",
                 results_seen, descriptors_seen, reports_seen);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
